// ===== design/dedup_reply_fifo_unit_defines.svh =====
// assertion macros for the deduplicating reply queue
`ifndef DEDUP_REPLY_FIFO_UNIT_DEFINES_SVH
`define DEDUP_REPLY_FIFO_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define DRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define DRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/drf_pkg.sv =====
// shared types and constants of the deduplicating reply queue
`timescale 1ns / 1ps

package drf_pkg;

   // sizes
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int NODE_W          = 16;
   localparam int FLAG_W          = 3;
   localparam int BATCH_W         = 5;
   localparam int MAXIDS_W        = 8;
   localparam int FILL_W          = 5;
   localparam int MODE_W          = 3;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 16;

   // register reset values
   localparam logic [NODE_W-1:0]  NODE_MAX_RST     = 16'd255;
   localparam logic [FLAG_W-1:0]  FLAG_MAX_RST     = 3'd7;
   localparam logic [FLAG_W-1:0]  CONFIRM_CODE_RST = 3'd7;
   localparam logic [BATCH_W-1:0] BATCH_LIMIT_RST  = 5'd8;

   // operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH    = 3'd0,
      MODE_CONFIRM = 3'd1,
      MODE_POP     = 3'd2,
      MODE_DRAIN   = 3'd3,
      MODE_CLEAR   = 3'd4
   } mode_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_MAX     = 2'd0,
      CSR_FLAG_MAX     = 2'd1,
      CSR_CONFIRM_CODE = 2'd2,
      CSR_BATCH_LIMIT  = 2'd3
   } csr_index_type;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_POP,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [NODE_W-1:0]   node_id;
      logic [FLAG_W-1:0]   id_flag;
      logic [MAXIDS_W-1:0] max_ids;
   } req_word_type;

   typedef struct packed {
      logic              ok;
      logic [NODE_W-1:0] out_node_id;
      logic [FLAG_W-1:0] out_flag;
      logic [FILL_W-1:0] fill_count;
      logic              last;
   } rsp_word_type;

   // one queue slot
   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [FLAG_W-1:0] flag;
   } entry_type;

endpackage

// ===== design/dedup_reply_fifo_unit.sv =====
// deduplicating ring queue of node id and flag entries, top level
`timescale 1ns / 1ps

// Ring queue of (node id, flag) entries kept in a single one-port-read, one-port-write
// synchronous memory with a registered read; each node id is held at most once.
// One request word is handled at a time. A push walks the held entries from the head,
// one memory read per cycle, until it meets the id or the last held entry; an empty queue
// or a rejected push skips the walk. Drain emits one response word per cycle, back to back
// while the consumer keeps ready high. The response sits in an output register, so ready
// toward the consumer only stalls the block, never loses a word. Every response carries
// the fill count after it.
module dedup_reply_fifo_unit #(
   parameter int QUEUE_DEPTH = drf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  drf_pkg::req_word_type                 req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output drf_pkg::rsp_word_type                 rsp_word,
   input  logic                                  csr_we,
   input  logic [drf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [drf_pkg::CSR_DATA_W-1:0]        csr_wdata
);

`include "dedup_reply_fifo_unit_defines.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > drf_pkg::BATCH_W) ? CNT_W : drf_pkg::BATCH_W;

   // configuration registers
   logic [drf_pkg::NODE_W-1:0]  node_max_ff;
   logic [drf_pkg::FLAG_W-1:0]  flag_max_ff;
   logic [drf_pkg::FLAG_W-1:0]  confirm_ff;
   logic [drf_pkg::BATCH_W-1:0] batch_ff;

   // control and queue pointers
   drf_pkg::state_type    state_ff, state_in;
   drf_pkg::req_word_type req_ff, req_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      held_ff, held_in;
   logic [PTR_W-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [drf_pkg::BATCH_W-1:0] drain_left_ff, drain_left_in;
   drf_pkg::rsp_word_type reply_ff, reply_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   drf_pkg::rsp_word_type rsp_ff, rsp_in;

   // entry memory and its ports
   drf_pkg::entry_type entry_mem [QUEUE_DEPTH];
   drf_pkg::entry_type rd_data_ff;
   logic               mem_we;
   logic [PTR_W-1:0]   mem_waddr;
   drf_pkg::entry_type mem_wdata;
   logic               mem_re;
   logic [PTR_W-1:0]   mem_raddr;

   // decode helpers
   logic [drf_pkg::FLAG_W-1:0]   push_flag;
   logic                         push_bad;
   logic                         held_empty;
   logic                         held_full;
   logic [CNT_W-1:0]             held_dec;
   logic                         out_free;
   logic                         scan_match;
   logic                         scan_end;
   logic [drf_pkg::MAXIDS_W-1:0] lim_a;
   logic [drf_pkg::BATCH_W-1:0]  lim_b;
   logic [drf_pkg::BATCH_W-1:0]  drain_n;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         node_max_ff <= drf_pkg::NODE_MAX_RST;
         flag_max_ff <= drf_pkg::FLAG_MAX_RST;
         confirm_ff  <= drf_pkg::CONFIRM_CODE_RST;
         batch_ff    <= drf_pkg::BATCH_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            drf_pkg::CSR_NODE_MAX:     node_max_ff <= csr_wdata;
            drf_pkg::CSR_FLAG_MAX:     flag_max_ff <= csr_wdata[drf_pkg::FLAG_W-1:0];
            drf_pkg::CSR_CONFIRM_CODE: confirm_ff  <= csr_wdata[drf_pkg::FLAG_W-1:0];
            drf_pkg::CSR_BATCH_LIMIT:  batch_ff    <= csr_wdata[drf_pkg::BATCH_W-1:0];
            default: ;
         endcase
      end
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[mem_raddr];
      end
   end

   // request decode
   always_comb begin
      push_flag  = (req_ff.mode == drf_pkg::MODE_CONFIRM) ? confirm_ff : req_ff.id_flag;
      push_bad   = (req_ff.node_id == '0) || (req_ff.node_id > node_max_ff) ||
                   (push_flag > flag_max_ff);
      held_empty = (held_ff == '0);
      held_full  = (held_ff == CNT_W'(QUEUE_DEPTH));
      held_dec   = held_ff - CNT_W'(1);
      out_free   = !rsp_valid_ff || rsp_ready;
      scan_match = (rd_data_ff.node == req_ff.node_id);
      scan_end   = (scan_idx_ff == held_dec);
   end

   // drain count: smallest of request, batch limit, result bound and fill
   always_comb begin
      lim_a = (req_ff.max_ids < drf_pkg::MAXIDS_W'(batch_ff)) ?
              req_ff.max_ids : drf_pkg::MAXIDS_W'(batch_ff);
      lim_b = (lim_a > drf_pkg::MAXIDS_W'(drf_pkg::MAX_RESULTS)) ?
              drf_pkg::BATCH_W'(drf_pkg::MAX_RESULTS) : lim_a[drf_pkg::BATCH_W-1:0];
      drain_n = (CMP_W'(held_ff) < CMP_W'(lim_b)) ? drf_pkg::BATCH_W'(held_ff) : lim_b;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         drf_pkg::ST_IDLE: begin
            if (req_valid) state_in = drf_pkg::ST_DISPATCH;
         end
         drf_pkg::ST_DISPATCH: begin
            case (req_ff.mode)
               drf_pkg::MODE_PUSH, drf_pkg::MODE_CONFIRM: begin
                  state_in = (push_bad || held_empty) ? drf_pkg::ST_REPLY
                                                      : drf_pkg::ST_SEARCH;
               end
               drf_pkg::MODE_POP: begin
                  state_in = held_empty ? drf_pkg::ST_REPLY : drf_pkg::ST_POP;
               end
               drf_pkg::MODE_DRAIN: begin
                  state_in = (drain_n == '0) ? drf_pkg::ST_REPLY : drf_pkg::ST_DRAIN;
               end
               default: state_in = drf_pkg::ST_REPLY;
            endcase
         end
         drf_pkg::ST_SEARCH: begin
            if (scan_match || scan_end) state_in = drf_pkg::ST_REPLY;
         end
         drf_pkg::ST_POP: state_in = drf_pkg::ST_REPLY;
         drf_pkg::ST_DRAIN: begin
            if (out_free && drain_left_ff == drf_pkg::BATCH_W'(1)) begin
               state_in = drf_pkg::ST_IDLE;
            end
         end
         drf_pkg::ST_REPLY: begin
            if (out_free) state_in = drf_pkg::ST_IDLE;
         end
         default: state_in = drf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_ready      = 1'b0;
      req_in         = req_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      held_in        = held_ff;
      scan_ptr_in    = scan_ptr_ff;
      scan_idx_in    = scan_idx_ff;
      drain_left_in  = drain_left_ff;
      reply_in       = reply_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_in         = rsp_ff;
      mem_we         = 1'b0;
      mem_waddr      = tail_ff;
      mem_wdata.node = req_ff.node_id;
      mem_wdata.flag = push_flag;
      mem_re         = 1'b0;
      mem_raddr      = head_ff;
      case (state_ff)
         drf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) req_in = req_word;
         end
         drf_pkg::ST_DISPATCH: begin
            reply_in      = '0;
            reply_in.last = 1'b1;
            case (req_ff.mode)
               drf_pkg::MODE_PUSH, drf_pkg::MODE_CONFIRM: begin
                  if (!push_bad) begin
                     if (held_empty) begin
                        // nothing to search, append at once
                        mem_we      = 1'b1;
                        tail_in     = ring_next(tail_ff);
                        held_in     = held_ff + CNT_W'(1);
                        reply_in.ok = 1'b1;
                     end else begin
                        mem_re      = 1'b1;
                        scan_ptr_in = head_ff;
                        scan_idx_in = '0;
                     end
                  end
               end
               drf_pkg::MODE_POP: begin
                  mem_re = !held_empty;
               end
               drf_pkg::MODE_DRAIN: begin
                  mem_re        = (drain_n != '0);
                  drain_left_in = drain_n;
               end
               drf_pkg::MODE_CLEAR: begin
                  head_in     = '0;
                  tail_in     = '0;
                  held_in     = '0;
                  reply_in.ok = 1'b1;
               end
               default: ;
            endcase
         end
         drf_pkg::ST_SEARCH: begin
            if (scan_match) begin
               // duplicate id: rewrite its flag only
               mem_we         = 1'b1;
               mem_waddr      = scan_ptr_ff;
               mem_wdata.node = rd_data_ff.node;
               reply_in.ok    = 1'b1;
            end else if (scan_end) begin
               if (!held_full) begin
                  mem_we      = 1'b1;
                  tail_in     = ring_next(tail_ff);
                  held_in     = held_ff + CNT_W'(1);
                  reply_in.ok = 1'b1;
               end
            end else begin
               mem_re      = 1'b1;
               mem_raddr   = ring_next(scan_ptr_ff);
               scan_ptr_in = ring_next(scan_ptr_ff);
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end
         drf_pkg::ST_POP: begin
            reply_in.ok          = 1'b1;
            reply_in.out_node_id = rd_data_ff.node;
            reply_in.out_flag    = rd_data_ff.flag;
            head_in              = ring_next(head_ff);
            held_in              = held_dec;
         end
         drf_pkg::ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.ok          = 1'b1;
               rsp_in.out_node_id = rd_data_ff.node;
               rsp_in.out_flag    = confirm_ff;
               rsp_in.fill_count  = drf_pkg::FILL_W'(held_dec);
               rsp_in.last        = (drain_left_ff == drf_pkg::BATCH_W'(1));
               head_in            = ring_next(head_ff);
               held_in            = held_dec;
               drain_left_in      = drain_left_ff - drf_pkg::BATCH_W'(1);
               // fetch the next head while this word goes out
               mem_re             = (drain_left_ff != drf_pkg::BATCH_W'(1));
               mem_raddr          = ring_next(head_ff);
            end
         end
         drf_pkg::ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in            = reply_ff;
               rsp_in.fill_count = drf_pkg::FILL_W'(held_ff);
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drf_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_ptr_ff   <= scan_ptr_in;
      scan_idx_ff   <= scan_idx_in;
      drain_left_ff <= drain_left_in;
      reply_ff      <= reply_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `DRF_ASSERT_NOW(a_held_bound, clock, reset, 1'b1, held_ff <= CNT_W'(QUEUE_DEPTH),
      "fill count above queue depth")
   `DRF_ASSERT_NOW(a_mid_batch_drain, clock, reset, rsp_valid_ff && !rsp_ff.last,
      state_ff == drf_pkg::ST_DRAIN, "non-final word outside a drain")
   `DRF_ASSERT_NOW(a_drain_has_work, clock, reset, state_ff == drf_pkg::ST_DRAIN,
      (held_ff != '0) && (drain_left_ff != '0), "drain running on empty queue")
   `DRF_ASSERT_NEXT(a_search_advances, clock, reset,
      state_ff == drf_pkg::ST_SEARCH && !scan_match && !scan_end,
      scan_idx_ff == $past(scan_idx_ff) + CNT_W'(1), "search index did not advance")

endmodule

// ===== sim/dedup_reply_fifo_unit_tb.sv =====
// testbench for the deduplicating reply queue: directed and random words checked against a mirror
`timescale 1ns / 1ps

module dedup_reply_fifo_unit_tb;

   localparam int DEPTH          = drf_pkg::QUEUE_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 24;
   localparam int PHASE_WORDS    = 52;
   // codes past clear carry no operation
   localparam logic [drf_pkg::MODE_W-1:0] MODE_FIRST_UNUSED =
      drf_pkg::MODE_W'(drf_pkg::MODE_CLEAR + 1);
   localparam logic [drf_pkg::MODE_W-1:0] MODE_TOP          = '1;

   // mirror of the queue contents, registers and replies still owed
   class dedup_queue_mirror;
      logic [drf_pkg::NODE_W-1:0]  slot_node [DEPTH];
      logic [drf_pkg::FLAG_W-1:0]  slot_flag [DEPTH];
      int unsigned                 head_pos;
      int unsigned                 tail_pos;
      int unsigned                 held;
      logic [drf_pkg::NODE_W-1:0]  node_max;
      logic [drf_pkg::FLAG_W-1:0]  flag_max;
      logic [drf_pkg::FLAG_W-1:0]  confirm_code;
      logic [drf_pkg::BATCH_W-1:0] batch_limit;
      drf_pkg::rsp_word_type       replies_due [$];
      int unsigned                 mismatches;

      function new();
         head_pos     = 0;
         tail_pos     = 0;
         held         = 0;
         node_max     = drf_pkg::NODE_MAX_RST;
         flag_max     = drf_pkg::FLAG_MAX_RST;
         confirm_code = drf_pkg::CONFIRM_CODE_RST;
         batch_limit  = drf_pkg::BATCH_LIMIT_RST;
         mismatches   = 0;
      endfunction

      function void set_reg(drf_pkg::csr_index_type idx,
                            logic [drf_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            drf_pkg::CSR_NODE_MAX:     node_max     = val[drf_pkg::NODE_W-1:0];
            drf_pkg::CSR_FLAG_MAX:     flag_max     = val[drf_pkg::FLAG_W-1:0];
            drf_pkg::CSR_CONFIRM_CODE: confirm_code = val[drf_pkg::FLAG_W-1:0];
            drf_pkg::CSR_BATCH_LIMIT:  batch_limit  = val[drf_pkg::BATCH_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned step(int unsigned p);
         return (p + 1 >= DEPTH) ? 0 : p + 1;
      endfunction

      // append, rewrite the flag of a held id, or reject
      function bit store(logic [drf_pkg::NODE_W-1:0] node, logic [drf_pkg::FLAG_W-1:0] flag);
         int unsigned p;
         p = head_pos;
         if (node == 0 || node > node_max || flag > flag_max) return 1'b0;
         for (int unsigned i = 0; i < held; i++) begin
            if (slot_node[p] == node) begin
               slot_flag[p] = flag;
               return 1'b1;
            end
            p = step(p);
         end
         if (held >= DEPTH) return 1'b0;
         slot_node[tail_pos] = node;
         slot_flag[tail_pos] = flag;
         tail_pos = step(tail_pos);
         held++;
         return 1'b1;
      endfunction

      function void take(output logic [drf_pkg::NODE_W-1:0] node,
                         output logic [drf_pkg::FLAG_W-1:0] flag);
         node     = slot_node[head_pos];
         flag     = slot_flag[head_pos];
         head_pos = step(head_pos);
         held--;
      endfunction

      function void due(bit ok, logic [drf_pkg::NODE_W-1:0] node,
                        logic [drf_pkg::FLAG_W-1:0] flag, bit last);
         drf_pkg::rsp_word_type r;
         r.ok          = ok;
         r.out_node_id = node;
         r.out_flag    = flag;
         r.fill_count  = drf_pkg::FILL_W'(held);
         r.last        = last;
         replies_due.push_back(r);
      endfunction

      // work out the replies one accepted request word causes
      function void note_word(drf_pkg::req_word_type w);
         int unsigned                n;
         bit                         ok;
         logic [drf_pkg::NODE_W-1:0] node;
         logic [drf_pkg::FLAG_W-1:0] flag;
         case (w.mode)
            drf_pkg::MODE_PUSH: begin
               ok = store(w.node_id, w.id_flag);
               due(ok, '0, '0, 1'b1);
            end
            drf_pkg::MODE_CONFIRM: begin
               ok = store(w.node_id, confirm_code);
               due(ok, '0, '0, 1'b1);
            end
            drf_pkg::MODE_POP: begin
               if (held == 0) begin
                  due(1'b0, '0, '0, 1'b1);
               end else begin
                  take(node, flag);
                  due(1'b1, node, flag, 1'b1);
               end
            end
            drf_pkg::MODE_DRAIN: begin
               n = 32'(w.max_ids);
               if (n > batch_limit) n = 32'(batch_limit);
               if (n > held) n = held;
               if (n > drf_pkg::MAX_RESULTS) n = drf_pkg::MAX_RESULTS;
               if (n == 0) begin
                  due(1'b0, '0, '0, 1'b1);
               end else begin
                  for (int unsigned k = 0; k < n; k++) begin
                     take(node, flag);
                     due(1'b1, node, confirm_code, k + 1 == n);
                  end
               end
            end
            drf_pkg::MODE_CLEAR: begin
               head_pos = 0;
               tail_pos = 0;
               held     = 0;
               due(1'b1, '0, '0, 1'b1);
            end
            default: due(1'b0, '0, '0, 1'b1);
         endcase
      endfunction

      // compare a reply word with the oldest one owed
      function void check_reply(drf_pkg::rsp_word_type got);
         drf_pkg::rsp_word_type want;
         if (replies_due.size() == 0) begin
            $error("reply word %h arrived with none owed", got);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            mismatches++;
         end
         if (got.out_node_id !== want.out_node_id) begin
            $error("out_node_id: expected %0d, got %0d", want.out_node_id, got.out_node_id);
            mismatches++;
         end
         if (got.out_flag !== want.out_flag) begin
            $error("out_flag: expected %0d, got %0d", want.out_flag, got.out_flag);
            mismatches++;
         end
         if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return replies_due.size();
      endfunction

      function int unsigned wrap_up();
         if (replies_due.size() != 0) begin
            $error("%0d reply words never arrived", replies_due.size());
            mismatches++;
         end
         return mismatches;
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   drf_pkg::req_word_type              req_word;
   logic                               rsp_valid;
   logic                               rsp_ready;
   drf_pkg::rsp_word_type              rsp_word;
   logic                               csr_we;
   logic [drf_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [drf_pkg::CSR_DATA_W-1:0]     csr_wdata;

   dedup_queue_mirror book;
   int unsigned       hold_left    = 0;
   int unsigned       quiet_cycles = 0;
   int unsigned       words_sent   = 0;
   bit                sender_steady = 1'b0;

   dedup_reply_fifo_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // unconstrained field values
   function automatic logic [drf_pkg::NODE_W-1:0] any_node();
      return drf_pkg::NODE_W'($urandom);
   endfunction

   function automatic logic [drf_pkg::FLAG_W-1:0] any_flag();
      return drf_pkg::FLAG_W'($urandom);
   endfunction

   function automatic logic [drf_pkg::MAXIDS_W-1:0] any_cnt();
      return drf_pkg::MAXIDS_W'($urandom);
   endfunction

   function automatic drf_pkg::req_word_type make_word(logic [drf_pkg::MODE_W-1:0] mode,
                                                       logic [drf_pkg::NODE_W-1:0] node,
                                                       logic [drf_pkg::FLAG_W-1:0] flag,
                                                       logic [drf_pkg::MAXIDS_W-1:0] cnt);
      drf_pkg::req_word_type w;
      w.mode    = mode;
      w.node_id = node;
      w.id_flag = flag;
      w.max_ids = cnt;
      return w;
   endfunction

   // ids mostly from a small pool so duplicates are common
   function automatic logic [drf_pkg::NODE_W-1:0] pick_node();
      int unsigned r;
      int unsigned lim;
      r   = $urandom_range(0, 99);
      lim = (book.node_max < 24) ? 32'(book.node_max) : 24;
      if (r < 70) return drf_pkg::NODE_W'($urandom_range(1, lim));
      if (r < 90) return drf_pkg::NODE_W'($urandom_range(1, book.node_max));
      return any_node();
   endfunction

   function automatic logic [drf_pkg::FLAG_W-1:0] pick_flag();
      if ($urandom_range(0, 99) < 85)
         return drf_pkg::FLAG_W'($urandom_range(0, book.flag_max));
      return any_flag();
   endfunction

   // reply side: random stalls, calm stretches and the long hold-off
   initial begin : reply_sink
      int unsigned stall_left;
      int unsigned calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(40, 150);
            else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // check each accepted reply word
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_reply(rsp_word);
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one request word and hold it until accepted
   task automatic send_word(drf_pkg::req_word_type w);
      int unsigned gap;
      gap = sender_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      book.note_word(w);
      words_sent++;
   endtask

   // stop offering and wait for every owed reply
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_reg(drf_pkg::csr_index_type idx,
                            logic [drf_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      book.set_reg(idx, val);
   endtask

   task automatic configure(logic [drf_pkg::NODE_W-1:0] nm, logic [drf_pkg::FLAG_W-1:0] fm,
                            logic [drf_pkg::FLAG_W-1:0] cc, logic [drf_pkg::BATCH_W-1:0] bl);
      settle();
      write_reg(drf_pkg::CSR_NODE_MAX, nm);
      write_reg(drf_pkg::CSR_FLAG_MAX, drf_pkg::CSR_DATA_W'(fm));
      write_reg(drf_pkg::CSR_CONFIRM_CODE, drf_pkg::CSR_DATA_W'(cc));
      write_reg(drf_pkg::CSR_BATCH_LIMIT, drf_pkg::CSR_DATA_W'(bl));
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // random traffic: mostly push runs and drains, some pops, clears and noise
   task automatic run_phase(int unsigned quota);
      int unsigned                  goal;
      int unsigned                  n;
      int unsigned                  base;
      int unsigned                  r;
      int unsigned                  pick;
      logic [drf_pkg::MAXIDS_W-1:0] cnt;
      goal          = words_sent + quota;
      sender_steady = ($urandom_range(0, 3) == 0);
      while (words_sent < goal) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            // run of consecutive ids, wrapping at node_max, long enough to fill the queue
            n    = $urandom_range(1, 18);
            base = $urandom_range(1, book.node_max);
            for (int unsigned k = 0; k < n; k++)
               send_word(make_word(drf_pkg::MODE_PUSH,
                                   drf_pkg::NODE_W'((base - 1 + k) % book.node_max + 1),
                                   pick_flag(), any_cnt()));
         end else if (r < 50) begin
            n = $urandom_range(1, 8);
            for (int unsigned k = 0; k < n; k++)
               send_word(make_word(($urandom_range(0, 3) == 0) ? drf_pkg::MODE_CONFIRM
                                                                : drf_pkg::MODE_PUSH,
                                   pick_node(), pick_flag(), any_cnt()));
         end else if (r < 65) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) cnt = 8'd0;
            else if (pick == 1) cnt = 8'hFF;
            else if (pick == 2) cnt = drf_pkg::MAXIDS_W'($urandom_range(1, 20));
            else cnt = any_cnt();
            send_word(make_word(drf_pkg::MODE_DRAIN, any_node(), any_flag(), cnt));
         end else if (r < 75) begin
            n = $urandom_range(1, 4);
            for (int unsigned k = 0; k < n; k++)
               send_word(make_word(drf_pkg::MODE_POP, any_node(), any_flag(), any_cnt()));
         end else if (r < 80) begin
            send_word(make_word(drf_pkg::MODE_CLEAR, any_node(), any_flag(), any_cnt()));
         end else begin
            send_word(make_word(drf_pkg::MODE_W'($urandom_range(0, MODE_TOP)),
                                any_node(), any_flag(), any_cnt()));
         end
      end
      sender_steady = 1'b0;
   endtask

   // stimulus
   initial begin
      book      = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset register values
      send_word(make_word(drf_pkg::MODE_POP, 16'd0, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_DRAIN, 16'd0, 3'd0, 8'hFF));
      send_word(make_word(MODE_FIRST_UNUSED, 16'd1, 3'd1, 8'd1));
      send_word(make_word(MODE_TOP, 16'hFFFF, 3'd7, 8'hFF));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'd0, 3'd1, 8'd0));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'd256, 3'd1, 8'd0));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'd255, 3'd7, 8'd0));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'd1, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'd1, 3'd5, 8'd0));
      send_word(make_word(drf_pkg::MODE_CONFIRM, 16'd2, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_CONFIRM, 16'd255, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_DRAIN, 16'd0, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_POP, 16'd0, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_DRAIN, 16'd0, 3'd0, 8'hFF));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'd3, 3'd2, 8'd0));
      send_word(make_word(drf_pkg::MODE_CLEAR, 16'd0, 3'd0, 8'd0));

      // directed, narrow flags and a confirm code above flag_max
      configure(16'hFFFF, 3'd3, 3'd6, 5'd16);
      send_word(make_word(drf_pkg::MODE_PUSH, 16'hFFFF, 3'd3, 8'd0));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'd100, 3'd4, 8'd0));
      send_word(make_word(drf_pkg::MODE_CONFIRM, 16'd5, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_PUSH, 16'hFFFF, 3'd0, 8'd0));
      send_word(make_word(drf_pkg::MODE_DRAIN, 16'd0, 3'd0, 8'd1));
      send_word(make_word(drf_pkg::MODE_DRAIN, 16'd0, 3'd0, 8'hFF));

      // widest settings, with the reply side held off while pushes keep coming
      configure(16'hFFFF, 3'd7, 3'd0, 5'd16);
      @(posedge clock);
      hold_left     = HOLD_CYCLES;
      sender_steady = 1'b1;
      for (int unsigned k = 0; k < 24; k++)
         send_word(make_word(drf_pkg::MODE_PUSH, drf_pkg::NODE_W'(k + 1),
                             any_flag(), any_cnt()));
      sender_steady = 1'b0;
      run_phase(PHASE_WORDS);

      // narrowest settings
      configure(16'd1, 3'd0, 3'd0, 5'd1);
      run_phase(PHASE_WORDS);

      // drains always come back empty
      configure(16'd16, 3'd7, 3'd3, 5'd0);
      run_phase(PHASE_WORDS);

      // random settings
      configure(drf_pkg::NODE_W'($urandom_range(1, 40)), any_flag(), any_flag(),
                drf_pkg::BATCH_W'($urandom_range(0, 16)));
      run_phase(PHASE_WORDS);
      configure(drf_pkg::NODE_W'($urandom_range(1, 16'hFFFF)), any_flag(), any_flag(),
                drf_pkg::BATCH_W'($urandom_range(0, 16)));
      run_phase(PHASE_WORDS);
      configure(drf_pkg::NODE_W'($urandom_range(1, 16'hFFFF)), any_flag(), any_flag(),
                drf_pkg::BATCH_W'($urandom_range(0, 16)));
      run_phase(PHASE_WORDS);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.wrap_up() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/drf_pkg.sv
design/dedup_reply_fifo_unit.sv
sim/dedup_reply_fifo_unit_tb.sv
